[design/assert_macros.svh]
// Assertion macros used by the allowlist RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, held off during reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

[design/mrual_pkg.sv]
// Types and constants shared by the source address allowlist modules.
`default_nettype none

package mrual_pkg;

  localparam int ADDR_W = 64;
  localparam int PORT_W = 16;
  localparam int TRANS_W = 2;
  localparam int OCC_W = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_VERIFY = 1'b1;
  localparam logic FAM_IPV4 = 1'b0;
  localparam logic FAM_IPV6 = 1'b1;

  // Register index of the fallback switch, taken from paddr[2].
  localparam logic REG_FALLBACK = 1'b0;

  typedef struct packed {
    logic               family;
    logic [ADDR_W-1:0]  addr_high;
    logic [ADDR_W-1:0]  addr_low;
    logic [PORT_W-1:0]  port;
    logic [TRANS_W-1:0] transport;
  } entry_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic cmp;        // capture compare hits against the key
    logic shift;      // apply a shift toward the back this cycle
    logic shift_all;  // every cell shifts (insert), else only up to the hit
  } cell_ctl_t;

endpackage

`default_nettype wire

[design/mrual_if.sv]
// Handshake channels carrying allowlist requests and responses.
`default_nettype none

interface mrual_req_if;
  import mrual_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic               addr_family;
  logic [ADDR_W-1:0]  addr_high;
  logic [ADDR_W-1:0]  addr_low;
  logic [PORT_W-1:0]  port_number;
  logic [TRANS_W-1:0] transport_kind;

  modport source (output valid, cmd, addr_family, addr_high, addr_low, port_number,
                  transport_kind, input ready);
  modport sink (input valid, cmd, addr_family, addr_high, addr_low, port_number,
                transport_kind, output ready);
endinterface

interface mrual_rsp_if;
  import mrual_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             inserted;
  logic             evicted;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, accepted, inserted, evicted, occupancy, input ready);
  modport sink (input valid, accepted, inserted, evicted, occupancy, output ready);
endinterface

`default_nettype wire

[design/mrual_cell.sv]
// One list slot: holds an entry, compares it with the key and shifts backward.
`default_nettype none

module mrual_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire mrual_pkg::cell_ctl_t ctl,
  input  wire mrual_pkg::entry_t key,
  input  wire                    in_use,
  input  wire mrual_pkg::entry_t left,
  input  wire                    before_in,
  output mrual_pkg::entry_t      data,
  output logic                   hit_full,
  output logic                   hit_ep,
  output logic                   before_out
);
  import mrual_pkg::*;

  entry_t data_q;
  logic   hit_full_q;
  logic   hit_ep_q;
  logic   ep_eq;

  // Endpoint match ignores transport; the add check also wants transport.
  assign ep_eq = (data_q.family == key.family) && (data_q.addr_high == key.addr_high) &&
                 (data_q.addr_low == key.addr_low) && (data_q.port == key.port);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_full_q <= 1'b0;
      hit_ep_q   <= 1'b0;
    end else if (ctl.cmp) begin
      hit_ep_q   <= in_use && ep_eq;
      hit_full_q <= in_use && ep_eq && (data_q.transport == key.transport);
    end
  end

  // A move to front shifts only the cells up to and including the first hit.
  always_ff @(posedge clk) begin
    if (ctl.shift && (ctl.shift_all || !before_in)) begin
      data_q <= left;
    end
  end

  assign data       = data_q;
  assign hit_full   = hit_full_q;
  assign hit_ep     = hit_ep_q;
  assign before_out = before_in || hit_ep_q;

endmodule

`default_nettype wire

[design/mru_source_address_allowlist.sv]
// Top level of the bounded most-recently-used source address allowlist.
// Each item passes through the compare, select and update steps of the cell chain;
// the result is registered in the update step, which waits while the response is held.
// A new item is taken only after the last one's result has been loaded.
// Synchronous reset empties the list and clears fallback; slot contents stay.
`default_nettype none
`include "assert_macros.svh"

module mru_source_address_allowlist #(
  parameter int CAPACITY = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  mrual_req_if.sink                       request,
  mrual_rsp_if.source                     response,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [mrual_pkg::PADDR_W-1:0]    paddr,
  input  wire [mrual_pkg::PDATA_W-1:0]    pwdata,
  output logic [mrual_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready
);
  import mrual_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_SEL, ST_DONE} state_t;

  state_t          state;
  logic            cmd_q;
  entry_t          key_q;
  entry_t          sel_q;
  logic            any_full_q;
  logic            any_ep_q;
  logic [CNT_W-1:0] count;
  logic            fallback;

  logic            out_valid;
  logic            out_accepted;
  logic            out_inserted;
  logic            out_evicted;
  logic [OCC_W-1:0] out_occupancy;

  cell_ctl_t       ctl;
  entry_t          front;
  entry_t          cell_data [CAPACITY];
  logic [CAPACITY-1:0] hit_full;
  logic [CAPACITY-1:0] hit_ep;
  logic [CAPACITY-1:0] in_use;
  logic [CAPACITY:0]   hit_prior;
  entry_t          sel_next;
  logic            load_out;
  logic            is_full;
  logic            res_accepted;
  logic            res_inserted;
  logic            do_shift;
  logic            cfg_wr;

  assign request.ready = (state == ST_IDLE);
  assign load_out      = (state == ST_DONE) && (!out_valid || response.ready);
  assign is_full       = (count == CNT_W'(CAPACITY));

  assign res_inserted = (cmd_q == CMD_ADD) && !any_full_q;
  assign res_accepted = (cmd_q == CMD_VERIFY) && (fallback || any_ep_q);
  assign do_shift     = res_inserted || ((cmd_q == CMD_VERIFY) && !fallback && any_ep_q);

  always_comb begin
    ctl.cmp       = (state == ST_CMP);
    ctl.shift     = load_out && do_shift;
    ctl.shift_all = (cmd_q == CMD_ADD);
  end

  assign front        = (cmd_q == CMD_ADD) ? key_q : sel_q;
  assign hit_prior[0] = 1'b0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t left_k;
    assign in_use[k] = (CNT_W'(k) < count);
    if (k == 0) begin : g_head
      assign left_k = front;
    end else begin : g_body
      assign left_k = cell_data[k-1];
    end
    mrual_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .key        (key_q),
      .in_use     (in_use[k]),
      .left       (left_k),
      .before_in  (hit_prior[k]),
      .data       (cell_data[k]),
      .hit_full   (hit_full[k]),
      .hit_ep     (hit_ep[k]),
      .before_out (hit_prior[k+1])
    );
  end

  // Gather the entry at the first endpoint hit; at most one cell contributes.
  always_comb begin
    sel_next = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (hit_ep[k] && !hit_prior[k]) begin
        sel_next = sel_next | cell_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (request.valid) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_SEL;
        end
        ST_SEL: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
        if (res_inserted && !is_full) begin
          count <= count + 1'b1;
        end
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end

    if (request.valid && request.ready) begin
      cmd_q               <= request.cmd;
      key_q.family        <= request.addr_family;
      key_q.port          <= request.port_number;
      key_q.transport     <= request.transport_kind;
      // IPv4 keeps only the low 32 address bits.
      if (request.addr_family == FAM_IPV4) begin
        key_q.addr_high <= '0;
        key_q.addr_low  <= {32'b0, request.addr_low[31:0]};
      end else begin
        key_q.addr_high <= request.addr_high;
        key_q.addr_low  <= request.addr_low;
      end
    end

    if (state == ST_SEL) begin
      sel_q      <= sel_next;
      any_full_q <= |hit_full;
      any_ep_q   <= hit_prior[CAPACITY];
    end

    if (load_out) begin
      out_accepted <= res_accepted;
      out_inserted <= res_inserted;
      out_evicted  <= res_inserted && is_full;
      out_occupancy <= (res_inserted && !is_full) ? OCC_W'(count + 1'b1) : OCC_W'(count);
    end
  end

  assign response.valid     = out_valid;
  assign response.accepted  = out_accepted;
  assign response.inserted  = out_inserted;
  assign response.evicted   = out_evicted;
  assign response.occupancy = out_occupancy;

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_FALLBACK)) begin
      fallback <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_FALLBACK) ? {{(PDATA_W-1){1'b0}}, fallback} : '0;

  `ASSERT_NEXT(a_count_hold, clk, rst, !load_out, $stable(count), "count changed without a result")
  `ASSERT_PROP(a_result_from_done, clk, rst, $rose(out_valid) |-> $past(state == ST_DONE),
    "result appeared outside the update step")
  `ASSERT_PROP(a_evict_when_full, clk, rst,
    (out_valid && out_evicted) |-> (out_inserted && (out_occupancy == OCC_W'(CAPACITY))),
    "eviction without an insert into a full list")
  `ASSERT_PROP(a_result_exclusive, clk, rst, out_valid |-> !(out_accepted && out_inserted),
    "verify and add results both set")

endmodule

`default_nettype wire

[bench/mru_source_address_allowlist_tb.sv]
// Self-checking testbench for the source address allowlist with a mirrored list model.
`timescale 1ns / 1ps

module mru_source_address_allowlist_tb;
  import mrual_pkg::*;

  localparam int CAPACITY = 16;
  localparam logic [PADDR_W-1:0] ADDR_FALLBACK = {REG_FALLBACK, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_FALLBACK, 2'b00};

  typedef struct packed {
    logic               cmd;
    logic               family;
    logic [ADDR_W-1:0]  addr_high;
    logic [ADDR_W-1:0]  addr_low;
    logic [PORT_W-1:0]  port;
    logic [TRANS_W-1:0] transport;
  } request_t;

  typedef struct packed {
    logic             accepted;
    logic             inserted;
    logic             evicted;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // Mirror of the ordered endpoint list; slot 0 is the front.
  class allowlist_mirror;
    entry_t      slots[CAPACITY];
    int unsigned held;
    logic        fallback;
    result_t     pending[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      held = 0;
      fallback = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      if (addr[2] == REG_FALLBACK) fallback = data[0];
    endfunction

    // Family, address and port decide a source check; transport does not.
    function bit same_source(entry_t a, entry_t b);
      return a.family == b.family && a.addr_high == b.addr_high &&
             a.addr_low == b.addr_low && a.port == b.port;
    endfunction

    function void move_to_front(int unsigned n, entry_t e);
      int unsigned k;
      for (k = n; k > 0; k--) slots[k] = slots[k - 1];
      slots[0] = e;
    endfunction

    function void predict_item(request_t r);
      entry_t      key;
      result_t     want;
      int          hit;
      int unsigned i;
      int unsigned keep;
      key.family = r.family;
      key.addr_high = (r.family == FAM_IPV4) ? '0 : r.addr_high;
      key.addr_low = (r.family == FAM_IPV4) ? {32'h0, r.addr_low[31:0]} : r.addr_low;
      key.port = r.port;
      key.transport = r.transport;
      want = '0;
      hit = -1;
      if (r.cmd == CMD_ADD) begin
        for (i = 0; i < held; i++) begin
          if (hit < 0 && slots[i] == key) hit = int'(i);
        end
        if (hit < 0) begin
          keep = held;
          if (keep >= CAPACITY) begin
            keep = CAPACITY - 1;
            want.evicted = 1'b1;
          end
          move_to_front(keep, key);
          held = keep + 1;
          want.inserted = 1'b1;
        end
      end else if (fallback) begin
        want.accepted = 1'b1;
      end else begin
        for (i = 0; i < held; i++) begin
          if (hit < 0 && same_source(slots[i], key)) hit = int'(i);
        end
        if (hit >= 0) begin
          move_to_front(hit, slots[hit]);
          want.accepted = 1'b1;
        end
      end
      want.occupancy = held[OCC_W-1:0];
      pending.push_back(want);
    endfunction

    function void compare_field(string name, logic [OCC_W-1:0] want, logic [OCC_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: result with no item outstanding: expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("accepted", OCC_W'(want.accepted), OCC_W'(got.accepted));
      compare_field("inserted", OCC_W'(want.inserted), OCC_W'(got.inserted));
      compare_field("evicted", OCC_W'(want.evicted), OCC_W'(got.evicted));
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mrual_req_if request_ch ();
  mrual_rsp_if response_ch ();

  allowlist_mirror mirror;
  entry_t          endpoint_pool[$];
  bit              tx_steady;
  bit              rx_steady;
  bit              rx_long_hold;

  always #5 clk = ~clk;

  mru_source_address_allowlist #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .request(request_ch),
    .response(response_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always @(posedge clk) begin
    if (!rst && response_ch.valid && response_ch.ready) begin
      mirror.check_result({response_ch.accepted, response_ch.inserted,
                           response_ch.evicted, response_ch.occupancy});
    end
  end

  initial begin : response_ready_drive
    int unsigned hold_left;
    int unsigned pick;
    bit          big_hold_done;
    hold_left = 0;
    big_hold_done = 1'b0;
    response_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 999);
      if (hold_left != 0) begin
        hold_left--;
      end else if (!big_hold_done && mirror.results_seen >= 300) begin
        // One long hold-off while items keep coming, so the block backs up.
        big_hold_done = 1'b1;
        hold_left = 400;
      end else if (pick < 5) begin
        rx_steady = !rx_steady;
      end else if (!rx_steady && pick < 60) begin
        hold_left = $urandom_range(1, 4);
      end else if (!rx_steady && pick < 65) begin
        hold_left = $urandom_range(15, 40);
      end
      rx_long_hold = hold_left > 40;
      response_ch.ready <= (hold_left == 0);
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_steady || rx_long_hold) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t make_item(logic cmd, logic family, logic [ADDR_W-1:0] hi,
                                         logic [ADDR_W-1:0] lo, logic [PORT_W-1:0] port,
                                         logic [TRANS_W-1:0] transport);
    return {cmd, family, hi, lo, port, transport};
  endfunction

  function automatic entry_t random_endpoint();
    entry_t e;
    e.family = 1'($urandom_range(0, 1));
    e.addr_high = (e.family == FAM_IPV4) ? '0 : rand64();
    e.addr_low = (e.family == FAM_IPV4) ? {32'h0, $urandom} : rand64();
    e.port = PORT_W'($urandom);
    if ($urandom_range(0, 3) == 0) e.port = {PORT_W{e.port[0]}};
    e.transport = TRANS_W'($urandom_range(0, 3));
    return e;
  endfunction

  function automatic request_t endpoint_item(logic cmd, entry_t e);
    request_t r;
    r = make_item(cmd, e.family, e.addr_high, e.addr_low, e.port, e.transport);
    // Half of the IPv4 items carry noise in the bits that IPv4 ignores.
    if (e.family == FAM_IPV4 && $urandom_range(0, 1) == 1) begin
      r.addr_high = rand64();
      r.addr_low[63:32] = $urandom;
    end
    return r;
  endfunction

  // Mostly adds and checks of known endpoints, some near misses, some noise.
  function automatic request_t random_item();
    request_t    r;
    entry_t      e;
    int unsigned pick;
    int unsigned flip;
    pick = $urandom_range(0, 99);
    e = endpoint_pool[$urandom_range(0, endpoint_pool.size() - 1)];
    if (pick < 35) begin
      if ($urandom_range(0, 3) == 0) e.transport = TRANS_W'($urandom_range(0, 3));
      r = endpoint_item(CMD_ADD, e);
    end else if (pick < 88) begin
      if (pick >= 80) begin
        flip = $urandom_range(0, 127);
        case ($urandom_range(0, 2))
          0: e.family = ~e.family;
          1: e.port ^= PORT_W'(1) << $urandom_range(0, PORT_W - 1);
          default: begin
            if (e.family == FAM_IPV4) begin
              e.addr_low ^= ADDR_W'(1) << (flip % 32);
            end else if (flip < 64) begin
              e.addr_low ^= ADDR_W'(1) << flip;
            end else begin
              e.addr_high ^= ADDR_W'(1) << (flip - 64);
            end
          end
        endcase
      end
      r = endpoint_item(CMD_VERIFY, e);
      r.transport = TRANS_W'($urandom_range(0, 3));
    end else begin
      r = make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand64(), rand64(),
                    PORT_W'($urandom), TRANS_W'($urandom_range(0, 3)));
    end
    return r;
  endfunction

  task automatic send_item(input request_t r);
    int unsigned gap;
    gap = pick_gap();
    if ($urandom_range(0, 99) < 3) tx_steady = !tx_steady;
    if (gap != 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.cmd <= r.cmd;
    request_ch.addr_family <= r.family;
    request_ch.addr_high <= r.addr_high;
    request_ch.addr_low <= r.addr_low;
    request_ch.port_number <= r.port;
    request_ch.transport_kind <= r.transport;
    do @(posedge clk); while (!request_ch.ready);
    mirror.predict_item(r);
  endtask

  task automatic program_register(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mirror.write_register(addr, data);
    // Idling the bus after each write keeps back-to-back writes from driving it twice in one step.
    @(posedge clk);
  endtask

  task automatic settle();
    request_ch.valid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_directed();
    int unsigned i;
    send_item(make_item(CMD_VERIFY, FAM_IPV4, '0, 64'h0A00_0001, 16'd80, 2'd0));
    send_item(make_item(CMD_ADD, FAM_IPV4, '0, 64'hC0A8_0001, 16'd5000, 2'd0));
    // Same IPv4 endpoint with junk above bit 31 is a duplicate.
    send_item(make_item(CMD_ADD, FAM_IPV4, '1, 64'hDEAD_BEEF_C0A8_0001, 16'd5000, 2'd0));
    send_item(make_item(CMD_ADD, FAM_IPV4, '0, 64'hC0A8_0001, 16'd5000, 2'd1));
    send_item(make_item(CMD_VERIFY, FAM_IPV4, 64'h1234_5678_9ABC_DEF0,
                        64'hFFFF_FFFF_C0A8_0001, 16'd5000, 2'd3));
    send_item(make_item(CMD_VERIFY, FAM_IPV6, '0, 64'hC0A8_0001, 16'd5000, 2'd0));
    send_item(make_item(CMD_ADD, FAM_IPV6, '1, '1, 16'hFFFF, 2'd3));
    send_item(make_item(CMD_ADD, FAM_IPV6, '0, '0, 16'h0000, 2'd2));
    send_item(make_item(CMD_VERIFY, FAM_IPV6, '1, '1, 16'hFFFF, 2'd0));
    send_item(make_item(CMD_VERIFY, FAM_IPV6, '1, '1, 16'hFFFE, 2'd0));
    send_item(make_item(CMD_VERIFY, FAM_IPV4, '0, 64'hC0A8_0001, 16'd5000, 2'd2));
    // Fill the list and push one more so the back entry falls out.
    for (i = 1; i <= 13; i++) begin
      send_item(make_item(CMD_ADD, FAM_IPV6, ADDR_W'(i), ~ADDR_W'(i), PORT_W'(i),
                          TRANS_W'(i)));
    end
    send_item(make_item(CMD_VERIFY, FAM_IPV6, '0, '0, 16'h0000, 2'd1));
  endtask

  task automatic run_random(int unsigned items, int unsigned pool_size);
    int unsigned k;
    endpoint_pool.delete();
    for (k = 0; k < pool_size; k++) endpoint_pool.push_back(random_endpoint());
    for (k = 0; k < items; k++) send_item(random_item());
  endtask

  initial begin : stimulus
    mirror = new();
    rst = 1'b1;
    request_ch.valid = 1'b0;
    request_ch.cmd = CMD_ADD;
    request_ch.addr_family = FAM_IPV4;
    request_ch.addr_high = '0;
    request_ch.addr_low = '0;
    request_ch.port_number = '0;
    request_ch.transport_kind = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_long_hold = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    settle();
    program_register(ADDR_FALLBACK, '1);
    run_random(150, 8);
    settle();
    // Only bit 0 of the value counts, so this clears fallback.
    program_register(ADDR_FALLBACK, 32'h0000_0002);
    run_random(320, 20);
    settle();
    program_register(ADDR_FALLBACK, 32'h0000_0001);
    program_register(ADDR_SPARE, '0);
    run_random(130, 30);
    settle();
    program_register(ADDR_FALLBACK, '0);
    program_register(ADDR_SPARE, '1);
    run_random(330, 30);
    settle();

    if (mirror.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
